[src/lrukv_pkg.sv]
// Shared codes and constants for the LRU key-value cache.
package lrukv_pkg;

  // Width of the capacity register.
  localparam int CAP_W = 5;

  // Capacity after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Request operation codes.
  typedef enum logic {
    FUNC_GET = 1'b0,
    FUNC_PUT = 1'b1
  } func_t;

endpackage

[src/lru_key_value_cache_unit.sv]
// Fully associative key-value cache with least-recently-used replacement.
//
// Usage:
//   Requests enter on the in_ channel (valid/ready): in_func selects get or put,
//   in_req_key is the key and in_req_value the value to store on a put. Each
//   request word gives exactly one result word on the out_ channel: out_hit
//   tells whether the key was present, out_read_value carries the stored value
//   on a get hit (zero otherwise) and out_evicted flags a put that pushed out
//   the least recent entry.
//   A word is taken into the input register; the parallel key compare, age
//   update and write across all entries are then combinational and are
//   registered into the result register and the entry store together.
//   Throughput is one word per cycle while the receiver keeps out_ready high.
//   cfg_wr_en with cfg_wr_data sets the capacity; write it only while idle.
//   Reset empties the store and sets the capacity to 16; no clearing pass.
//   When the receiver stalls, the result register holds its word, the input
//   register takes one more word, and then in_ready drops until out_ready.
module lru_key_value_cache_unit #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Request channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_func,
  input  logic [KEY_BITS-1:0]         in_req_key,
  input  logic [VALUE_BITS-1:0]       in_req_value,
  // Result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_hit,
  output logic [VALUE_BITS-1:0]       out_read_value,
  output logic                        out_evicted,
  // Capacity register
  input  logic                        cfg_wr_en,
  input  logic [lrukv_pkg::CAP_W-1:0] cfg_wr_data
);

  localparam int AGE_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > lrukv_pkg::CAP_W) ? CNT_W : lrukv_pkg::CAP_W;

  // Capacity register.
  logic [lrukv_pkg::CAP_W-1:0] cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lrukv_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // Input register stage.
  logic                  s1_valid_r;
  lrukv_pkg::func_t      s1_func_r;
  logic [KEY_BITS-1:0]   s1_key_r;
  logic [VALUE_BITS-1:0] s1_value_r;
  logic                  s1_go;

  assign s1_go    = s1_valid_r && (!out_valid || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_func_r  <= lrukv_pkg::func_t'(in_func);
      s1_key_r   <= in_req_key;
      s1_value_r <= in_req_value;
    end
  end

  // Entry storage.
  logic [ENTRIES-1:0]    valid_r, valid_nxt;
  logic [AGE_W-1:0]      age_r     [ENTRIES];
  logic [AGE_W-1:0]      age_nxt   [ENTRIES];
  logic [KEY_BITS-1:0]   key_r     [ENTRIES];
  logic [VALUE_BITS-1:0] value_r   [ENTRIES];
  logic [CNT_W-1:0]      occ_r, occ_nxt;

  // Lookup and replacement choice.
  logic [ENTRIES-1:0]    match;
  logic [ENTRIES-1:0]    lru_oh;
  logic [ENTRIES-1:0]    free_oh;
  logic [ENTRIES-1:0]    wr_oh;
  logic                  hit;
  logic                  is_put;
  logic                  full;
  logic [CMP_W-1:0]      cap_ext;
  logic [CMP_W-1:0]      eff_cap;
  logic [CNT_W-1:0]      occ_m1;
  logic [AGE_W-1:0]      hit_age;
  logic [VALUE_BITS-1:0] hit_value;
  logic                  do_insert;
  logic                  do_evict;
  logic                  do_write;

  assign is_put = (s1_func_r == lrukv_pkg::FUNC_PUT);

  // Capacity of zero acts as one, above the entry count as the entry count.
  always_comb begin
    cap_ext = CMP_W'(cap_r);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full   = CMP_W'(occ_r) >= eff_cap;
  assign occ_m1 = occ_r - CNT_W'(1);

  // Parallel compare; keys of valid entries are unique, so at most one match.
  always_comb begin
    hit_age   = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid_r[i] && (key_r[i] == s1_key_r);
      lru_oh[i] = valid_r[i] && (CNT_W'(age_r[i]) == occ_m1);
      hit_age   = hit_age   | (age_r[i]   & {AGE_W{match[i]}});
      hit_value = hit_value | (value_r[i] & {VALUE_BITS{match[i]}});
    end
  end

  assign hit = |match;

  // Lowest free entry.
  assign free_oh = ~valid_r & (valid_r + ENTRIES'(1));

  assign do_insert = s1_go && is_put && !hit;
  assign do_evict  = do_insert && full;
  assign do_write  = s1_go && is_put;

  always_comb begin
    if (hit) begin
      wr_oh = match;
    end else if (full) begin
      wr_oh = lru_oh;
    end else begin
      wr_oh = free_oh;
    end
  end

  // Next ages, valid bits and occupancy.
  always_comb begin
    valid_nxt = valid_r;
    occ_nxt   = occ_r;
    for (int i = 0; i < ENTRIES; i++) begin
      age_nxt[i] = age_r[i];
    end
    if (s1_go && hit) begin
      // Touch: entries younger than the hit one age by one.
      for (int i = 0; i < ENTRIES; i++) begin
        if (match[i]) begin
          age_nxt[i] = '0;
        end else if (valid_r[i] && (age_r[i] < hit_age)) begin
          age_nxt[i] = age_r[i] + AGE_W'(1);
        end
      end
    end else if (do_insert) begin
      // Insert as most recent; every other valid entry ages by one.
      for (int i = 0; i < ENTRIES; i++) begin
        if (wr_oh[i]) begin
          age_nxt[i]   = '0;
          valid_nxt[i] = 1'b1;
        end else if (valid_r[i]) begin
          age_nxt[i] = age_r[i] + AGE_W'(1);
        end
      end
      if (!do_evict) begin
        occ_nxt = occ_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        age_r[i] <= age_nxt[i];
      end
    end
  end

  // Key and value writes; put hit rewrites the same key with the new value.
  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (do_write && wr_oh[i]) begin
        key_r[i]   <= s1_key_r;
        value_r[i] <= s1_value_r;
      end
    end
  end

  // Result register.
  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [VALUE_BITS-1:0] out_value_r;
  logic                  out_evicted_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_hit_r     <= hit;
      out_value_r   <= (hit && !is_put) ? hit_value : '0;
      out_evicted_r <= do_evict;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_value_r;
  assign out_evicted    = out_evicted_r;

  // Occupancy tracks the valid bits.
  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(occ_r))
    else $error("occupancy does not match valid entries");

  // Keys of valid entries stay unique.
  a_match_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> $onehot0(match))
    else $error("more than one entry matches the key");

  // Eviction has exactly one victim when it happens.
  a_lru_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    do_evict |-> $onehot(lru_oh))
    else $error("no single least recent entry to evict");

  // An eviction result never reports a hit.
  a_evict_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_evicted_r) |-> !out_hit_r)
    else $error("eviction reported together with a hit");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_hit_r)
      && $stable(out_value_r) && $stable(out_evicted_r)))
    else $error("result word changed while stalled");

endmodule

[tb/sv/lru_cache_checker.sv]
// Checker for the LRU key-value cache: predicts each result word and compares it.
module lru_cache_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        in_func,
  input  logic [15:0]                 in_req_key,
  input  logic [31:0]                 in_req_value,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        out_hit,
  input  logic [31:0]                 out_read_value,
  input  logic                        out_evicted,
  input  logic                        cfg_wr_en,
  input  logic [lrukv_pkg::CAP_W-1:0] cfg_wr_data,
  output int                          fail_count,
  output int                          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
  } lookup_result_t;

  // Shadow copy of the cache contents and the capacity register.
  logic                        slot_valid [SLOTS];
  logic [15:0]                 slot_key   [SLOTS];
  logic [31:0]                 slot_value [SLOTS];
  int                          slot_age   [SLOTS];
  int                          fill_level;
  logic [lrukv_pkg::CAP_W-1:0] capacity_reg;

  // Results still owed by the block, oldest first.
  lookup_result_t lookup_results_q [$];

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t ns: mismatch on %s, expected %h, got %h", $time, what, want, got);
    fail_count++;
  endtask

  // Apply one request to the shadow cache and return the word it should give.
  function automatic lookup_result_t predict_lookup(lrukv_pkg::func_t op,
                                                    logic [15:0] key,
                                                    logic [31:0] value);
    lookup_result_t res;
    int found;
    int slot;
    int best;
    bit any;
    int cap_eff;
    int age_ref;
    res = '0;
    found = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (found < 0 && slot_valid[i] && slot_key[i] == key) found = i;
    end

    if (found >= 0) begin
      res.hit = 1'b1;
      if (op == lrukv_pkg::FUNC_PUT) slot_value[found] = value;
      else res.read_value = slot_value[found];
      // The entry becomes the most recent; younger entries age by one.
      age_ref = slot_age[found];
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_valid[i] && slot_age[i] < age_ref) slot_age[i]++;
      end
      slot_age[found] = 0;
    end else if (op == lrukv_pkg::FUNC_PUT) begin
      cap_eff = (capacity_reg == 0) ? 1 : (capacity_reg > SLOTS) ? SLOTS : capacity_reg;
      slot = -1;
      if (fill_level < cap_eff) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot < 0 && !slot_valid[i]) slot = i;
        end
      end
      // No free slot allowed: push out the oldest valid entry.
      if (slot < 0) begin
        best = 0;
        any = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_valid[i] && (!any || slot_age[i] > slot_age[best])) begin
            best = i;
            any = 1'b1;
          end
        end
        if (any) begin
          slot_valid[best] = 1'b0;
          fill_level--;
          res.evicted = 1'b1;
          slot = best;
        end else begin
          slot = 0;
        end
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_valid[i]) slot_age[i]++;
      end
      slot_valid[slot] = 1'b1;
      slot_key[slot] = key;
      slot_value[slot] = value;
      slot_age[slot] = 0;
      fill_level++;
    end
    return res;
  endfunction

  // Watch both channels and the register port on every rising edge.
  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_valid[i] = 1'b0;
        slot_age[i] = 0;
      end
      fill_level = 0;
      capacity_reg = lrukv_pkg::CAP_RESET;
      lookup_results_q.delete();
      fail_count = 0;
      pending_count <= 0;
    end else begin
      // A result word is checked against the oldest prediction.
      if (out_valid && out_ready) begin
        if (lookup_results_q.size() == 0) begin
          report_mismatch("unexpected result word", 32'h0, out_read_value);
        end else begin
          want = lookup_results_q.pop_front();
          if (out_hit !== want.hit)
            report_mismatch("hit", 32'(want.hit), 32'(out_hit));
          if (out_read_value !== want.read_value)
            report_mismatch("read_value", want.read_value, out_read_value);
          if (out_evicted !== want.evicted)
            report_mismatch("evicted", 32'(want.evicted), 32'(out_evicted));
        end
      end
      if (cfg_wr_en) capacity_reg = cfg_wr_data;
      if (in_valid && in_ready)
        lookup_results_q.push_back(predict_lookup(lrukv_pkg::func_t'(in_func),
                                                  in_req_key, in_req_value));
      pending_count <= lookup_results_q.size();
    end
  end

endmodule

[tb/sv/tb_lru_key_value_cache_unit.sv]
// Testbench top for the LRU key-value cache: clock, reset, stimulus and verdict.
module tb_lru_key_value_cache_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam int RANDOM_WORDS = 50;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        in_func = lrukv_pkg::FUNC_GET;
  logic [15:0]                 in_req_key = '0;
  logic [31:0]                 in_req_value = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        out_hit;
  logic [31:0]                 out_read_value;
  logic                        out_evicted;
  logic                        cfg_wr_en = 1'b0;
  logic [lrukv_pkg::CAP_W-1:0] cfg_wr_data = '0;

  int fail_count;
  int pending_count;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  int cycle_count = 0;

  logic [15:0] key_pool [32];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  lru_key_value_cache_unit u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_req_key    (in_req_key),
    .in_req_value  (in_req_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_hit       (out_hit),
    .out_read_value(out_read_value),
    .out_evicted   (out_evicted),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  lru_cache_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_req_key    (in_req_key),
    .in_req_value  (in_req_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_hit       (out_hit),
    .out_read_value(out_read_value),
    .out_evicted   (out_evicted),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Receiver: random stalls, or one long hold-off when the stimulus asks for it.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Run guard.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("lru_key_value_cache_unit verification failed");
    $finish;
  end

  // Offer one request word and return at the edge that accepts it. Valid is
  // left high so that a following word can go out back to back.
  task automatic send_word(input lrukv_pkg::func_t op, input logic [15:0] key,
                           input logic [31:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= op;
    in_req_key <= key;
    in_req_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending and wait until every predicted word has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task automatic write_capacity(input int cap);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= lrukv_pkg::CAP_W'(cap);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int sub;
    int cap;
    int cap_eff;
    int pool_size;
    lrukv_pkg::func_t op;
    logic [15:0] key;
    logic [31:0] value;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: get on an empty store, extreme keys and values, put hit.
    send_word(lrukv_pkg::FUNC_GET, 16'h0000, 32'h0000_0000);
    send_word(lrukv_pkg::FUNC_PUT, 16'h0000, 32'h0000_0000);
    send_word(lrukv_pkg::FUNC_PUT, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(lrukv_pkg::FUNC_GET, 16'hFFFF, 32'h0000_0000);
    send_word(lrukv_pkg::FUNC_PUT, 16'h0000, 32'h1234_5678);
    send_word(lrukv_pkg::FUNC_GET, 16'h0000, 32'hFFFF_FFFF);

    // Capacity above the entry count: fill all entries, then one more evicts.
    write_capacity(31);
    for (int k = 1; k <= 15; k++)
      send_word(lrukv_pkg::FUNC_PUT, 16'(k), 32'(k * 32'h0101_0101));
    send_word(lrukv_pkg::FUNC_GET, 16'hFFFF, 32'h0);

    // Capacity lowered below occupancy, then capacity zero.
    write_capacity(2);
    send_word(lrukv_pkg::FUNC_PUT, 16'h8000, 32'h8000_0001);
    write_capacity(0);
    send_word(lrukv_pkg::FUNC_PUT, 16'h7FFF, 32'h7FFF_FFFE);
    send_word(lrukv_pkg::FUNC_GET, 16'h7FFF, 32'h0);

    // Random phases: three idling modes, four capacity settings each.
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 73;
        end
        1: begin
          send_idle_pct = 73;
          recv_idle_pct = 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int j = 0; j < 4; j++) begin
        sub = mode * 4 + j;
        case (sub)
          0: cap = 1;
          1: cap = 16;
          2: cap = 0;
          3: cap = 31;
          4: cap = 4;
          5: cap = 2;
          default: cap = $urandom_range(0, 31);
        endcase
        write_capacity(cap);

        // A key pool a little larger than the capacity gives hits and evictions.
        cap_eff = (cap == 0) ? 1 : (cap > 16) ? 16 : cap;
        pool_size = cap_eff + 1 + $urandom_range(0, 3);
        for (int p = 0; p < pool_size; p++) key_pool[p] = 16'($urandom);

        // Long receiver hold-off while the sender keeps offering words.
        if (mode == 2 && j == 0) hold_req = 1'b1;

        repeat (RANDOM_WORDS) begin
          op = lrukv_pkg::func_t'($urandom_range(0, 1));
          if ($urandom_range(0, 99) < 85)
            key = key_pool[5'($urandom_range(0, pool_size - 1))];
          else key = 16'($urandom);
          case ($urandom_range(0, 9))
            0: value = 32'h0000_0000;
            1: value = 32'hFFFF_FFFF;
            default: value = $urandom;
          endcase
          send_word(op, key, value);
        end
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("lru_key_value_cache_unit verification clean");
    end else begin
      $display("lru_key_value_cache_unit verification failed");
    end
    $finish;
  end

endmodule
